/* sv/r2sa_pkg.sv */
package r2sa_pkg;

  // Default capacity of the pair counter
  localparam int MAX_PAIRS_DEF = 65536;

  // Field and accumulator widths
  localparam int VAL_W    = 16;
  localparam int RSQ_W    = 32;
  localparam int RSS_W    = 48;
  localparam int TSS_W    = 47;
  localparam int SUM1_W   = 33;
  localparam int SUM2_W   = 47;
  localparam int SUMR_W   = 49;

  // Shared divider widths
  localparam int DVD_W    = 64;
  localparam int DVS_W    = 47;

  // Fixed-point constants
  localparam logic [RSQ_W-1:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [RSQ_W-1:0] RSQ_MIN    = 32'h8000_0000;
  localparam logic [DVD_W-1:0] SAT_LIMIT  = 64'h0000_0000_8001_0000;
  localparam logic [RSS_W-1:0] RSS_MAX    = 48'hFFFF_FFFF_FFFF;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_VAR = 2'd1,
    ST_SAT      = 2'd2
  } status_t;

  // Input beat
  typedef struct packed {
    logic signed [VAL_W-1:0] true_value;
    logic signed [VAL_W-1:0] predicted_value;
    logic                    last_pair;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [RSQ_W-1:0] r_squared;
    logic [RSS_W-1:0]        residual_sum;
    logic [TSS_W-1:0]        total_sum;
    status_t                 status;
  } out_beat_t;

  // Running sums handed from the accumulator to the sequencer
  typedef struct packed {
    logic signed [SUM1_W-1:0] sum_true;
    logic [SUM2_W-1:0]        sum_true_squares;
    logic [SUMR_W-1:0]        sum_residual_squares;
  } acc_sums_t;

endpackage

/* sv/r2sa_accum.sv */
module r2sa_accum #(
  parameter int MAX_PAIRS = r2sa_pkg::MAX_PAIRS_DEF,
  parameter int CNT_W     = $clog2(MAX_PAIRS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                take_i,
  input  logic                                clear_i,
  input  logic signed [r2sa_pkg::VAL_W-1:0]   true_i,
  input  logic signed [r2sa_pkg::VAL_W-1:0]   pred_i,
  output logic [CNT_W-1:0]                    count_o,
  output r2sa_pkg::acc_sums_t                 sums_o
);

  logic [CNT_W-1:0]                        cnt_r, cnt_nxt;
  r2sa_pkg::acc_sums_t                     sums_r, sums_nxt;
  logic signed [r2sa_pkg::VAL_W:0]         diff;
  logic signed [2*r2sa_pkg::VAL_W-1:0]     sq_true;
  logic signed [2*r2sa_pkg::VAL_W+1:0]     sq_diff;
  logic                                    room;

  // Square the target and the residual of this beat
  assign diff    = {true_i[r2sa_pkg::VAL_W-1], true_i} - {pred_i[r2sa_pkg::VAL_W-1], pred_i};
  assign sq_true = true_i * true_i;
  assign sq_diff = diff * diff;
  assign room    = (cnt_r < CNT_W'(MAX_PAIRS));

  // Advance the sums, drop beats once the counter is full
  always_comb begin
    cnt_nxt  = cnt_r;
    sums_nxt = sums_r;
    if (clear_i) begin
      cnt_nxt  = '0;
      sums_nxt = '0;
    end else if (take_i && room) begin
      cnt_nxt                       = cnt_r + CNT_W'(1);
      sums_nxt.sum_true             = sums_r.sum_true +
                                      {{(r2sa_pkg::SUM1_W-r2sa_pkg::VAL_W){true_i[r2sa_pkg::VAL_W-1]}},
                                       true_i};
      sums_nxt.sum_true_squares     = sums_r.sum_true_squares +
                                      r2sa_pkg::SUM2_W'(sq_true[2*r2sa_pkg::VAL_W-2:0]);
      sums_nxt.sum_residual_squares = sums_r.sum_residual_squares +
                                      r2sa_pkg::SUMR_W'(sq_diff[2*r2sa_pkg::VAL_W:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sums_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      sums_r <= sums_nxt;
    end
  end

  assign count_o = cnt_r;
  assign sums_o  = sums_r;

endmodule

/* sv/r2sa_divider.sv */
module r2sa_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [r2sa_pkg::DVD_W-1:0]    dividend_i,
  input  logic [r2sa_pkg::DVS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [r2sa_pkg::DVD_W-1:0]    quotient_o
);

  localparam int STEP_W = $clog2(r2sa_pkg::DVD_W);

  logic [r2sa_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [r2sa_pkg::DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [r2sa_pkg::DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0]           step_r;
  logic                        busy_r, done_r;
  logic [r2sa_pkg::DVS_W:0]    rem_sh;
  logic [r2sa_pkg::DVS_W:0]    rem_sub;
  logic                        fits;
  logic                        last_step;

  // One restoring step: shift in a dividend bit, subtract if it fits
  assign rem_sh    = {rem_r, dvd_r[r2sa_pkg::DVD_W-1]};
  assign fits      = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub   = rem_sh - {1'b0, dvs_r};
  assign rem_nxt   = fits ? rem_sub[r2sa_pkg::DVS_W-1:0] : rem_sh[r2sa_pkg::DVS_W-1:0];
  assign dvd_nxt   = {dvd_r[r2sa_pkg::DVD_W-2:0], fits};
  assign last_step = (step_r == STEP_W'(r2sa_pkg::DVD_W - 1));

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start_i) begin
      rem_r <= '0;
      dvd_r <= dividend_i;
      dvs_r <= divisor_i;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign done_o     = done_r;
  assign quotient_o = dvd_r;

endmodule

/* sv/r2_score_accumulator.sv */
// Channel | Ports                        | Beat
// input   | in_valid  in_ready  in_data  | r2sa_pkg::in_beat_t (true, predicted, last)
// result  | out_valid out_ready out_data | r2sa_pkg::out_beat_t (R^2, RSS, TSS, status)
//
// A pair that is not marked last is added into the sums in the cycle after it is taken;
// pairs may follow back to back while the sequencer is idle. A last pair sends the
// squared target sum over the count through the shared restoring divider in 64 steps,
// then, unless the total variance is zero, RSS/TSS in a second 64-step pass.
// rst_n is synchronous and clears the counter, the sums and the sequencer.
// A held result stalls only the final step; no pairs are taken until that step ends.
module r2_score_accumulator #(
  parameter int MAX_PAIRS = r2sa_pkg::MAX_PAIRS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r2sa_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r2sa_pkg::out_beat_t  out_data
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_MUL     = 8'b0000_0010,
    S_Q1_GO   = 8'b0000_0100,
    S_Q1_WAIT = 8'b0000_1000,
    S_TSS     = 8'b0001_0000,
    S_R2_GO   = 8'b0010_0000,
    S_R2_WAIT = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            take;
  logic                            acc_clear;
  logic [CNT_W-1:0]                count;
  r2sa_pkg::acc_sums_t             sums;

  logic [r2sa_pkg::SUM1_W-1:0]     s1_abs;
  logic [r2sa_pkg::DVD_W-1:0]      prod_r;
  logic [r2sa_pkg::TSS_W-1:0]      tss_r, tss_nxt;
  logic [r2sa_pkg::RSS_W-1:0]      rss_r, rss_nxt;
  logic                            zero_r;

  logic                            div_start;
  logic [r2sa_pkg::DVD_W-1:0]      div_dividend;
  logic [r2sa_pkg::DVS_W-1:0]      div_divisor;
  logic                            div_done;
  logic [r2sa_pkg::DVD_W-1:0]      div_quo;
  logic [CNT_W-1:0]                n_safe;

  logic                            out_valid_r;
  r2sa_pkg::out_beat_t             out_data_r, out_beat;
  logic                            out_free;
  logic [r2sa_pkg::RSQ_W-1:0]      r_calc;

  assign in_ready  = (state_r == S_IDLE);
  assign take      = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign acc_clear = (state_r == S_FIN) && out_free;

  r2sa_accum #(
    .MAX_PAIRS (MAX_PAIRS),
    .CNT_W     (CNT_W)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .take_i  (take),
    .clear_i (acc_clear),
    .true_i  (in_data.true_value),
    .pred_i  (in_data.predicted_value),
    .count_o (count),
    .sums_o  (sums)
  );

  // Feed the shared divider: S1^2 / n first, then rounded RSS * 2^16 / TSS
  assign n_safe       = (count == '0) ? CNT_W'(1) : count;
  assign div_start    = (state_r == S_Q1_GO) || (state_r == S_R2_GO);
  assign div_dividend = (state_r == S_Q1_GO) ? prod_r :
                        ({rss_r, 16'h0000} +
                         r2sa_pkg::DVD_W'(tss_r[r2sa_pkg::TSS_W-1:1]));
  assign div_divisor  = (state_r == S_Q1_GO) ? r2sa_pkg::DVS_W'(n_safe) : tss_r;

  r2sa_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Square the magnitude of the target sum
  assign s1_abs = sums.sum_true[r2sa_pkg::SUM1_W-1] ? (-sums.sum_true) : sums.sum_true;

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= s1_abs[31:0] * s1_abs[31:0];
    end
  end

  // Total and residual sums of squares; clamp TSS at zero, saturate RSS
  always_comb begin
    if ({17'h0, sums.sum_true_squares} >= div_quo) begin
      tss_nxt = sums.sum_true_squares - div_quo[r2sa_pkg::TSS_W-1:0];
    end else begin
      tss_nxt = '0;
    end
    if (sums.sum_residual_squares[r2sa_pkg::SUMR_W-1]) begin
      rss_nxt = r2sa_pkg::RSS_MAX;
    end else begin
      rss_nxt = sums.sum_residual_squares[r2sa_pkg::RSS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_TSS) begin
      tss_r  <= tss_nxt;
      rss_r  <= rss_nxt;
      zero_r <= (tss_nxt == '0);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (take && in_data.last_pair) state_nxt = S_MUL;
      S_MUL:     state_nxt = S_Q1_GO;
      S_Q1_GO:   state_nxt = S_Q1_WAIT;
      S_Q1_WAIT: if (div_done) state_nxt = S_TSS;
      S_TSS:     state_nxt = (tss_nxt == '0) ? S_FIN : S_R2_GO;
      S_R2_GO:   state_nxt = S_R2_WAIT;
      S_R2_WAIT: if (div_done) state_nxt = S_FIN;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Form R^2 from the quotient, saturate at the low end
  assign r_calc = r2sa_pkg::ONE_Q16 - div_quo[r2sa_pkg::RSQ_W-1:0];

  always_comb begin
    out_beat.residual_sum = rss_r;
    out_beat.total_sum    = tss_r;
    if (zero_r) begin
      out_beat.r_squared = '0;
      out_beat.status    = r2sa_pkg::ST_ZERO_VAR;
    end else if (div_quo > r2sa_pkg::SAT_LIMIT) begin
      out_beat.r_squared = r2sa_pkg::RSQ_MIN;
      out_beat.status    = r2sa_pkg::ST_SAT;
    end else begin
      out_beat.r_squared = r_calc;
      out_beat.status    = r2sa_pkg::ST_OK;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_clear) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_clear) begin
      out_data_r <= out_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/r2sa_checker.sv */
module r2sa_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input r2sa_pkg::in_beat_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input r2sa_pkg::out_beat_t  out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Stop taking pairs once a last pair is in
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_pair |=> !in_ready)
    else $error("pair taken while a result is being computed");

  // Report zero R^2 and zero total on zero variance
  a_zero_var: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == r2sa_pkg::ST_ZERO_VAR |->
      out_data.r_squared == '0 && out_data.total_sum == '0)
    else $error("zero-variance result carries nonzero values");

  // Pin R^2 to its floor when saturated
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == r2sa_pkg::ST_SAT |->
      out_data.r_squared == r2sa_pkg::RSQ_MIN)
    else $error("saturated result not at the floor");

  // Keep R^2 at or below one
  a_r2_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.r_squared <= $signed(r2sa_pkg::ONE_Q16))
    else $error("R squared above one");

endmodule

bind r2_score_accumulator r2sa_checker u_r2sa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
